>>> sv/x86_subset_position_tracer_unit_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef X86_SUBSET_POSITION_TRACER_UNIT_ASSERT_SVH
`define X86_SUBSET_POSITION_TRACER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define XPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define XPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/xpt_pkg.sv
package xpt_pkg;

   localparam int unsigned STACK_DEPTH_DEF = 64;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned REG_COUNT = 8;
   localparam int unsigned REG_AW = 3;
   localparam int unsigned PUSHAD_COUNT = 8;
   localparam int unsigned REQ_TDATA_W = 72;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 40;
   localparam int unsigned STATUS_W = 3;

   localparam logic [7:0] REG_SPAN = 8'd7;
   localparam logic [7:0] OP_INC = 8'h40;
   localparam logic [7:0] OP_INC_LAST = 8'h47;
   localparam logic [7:0] OP_DEC = 8'h48;
   localparam logic [7:0] OP_DEC_LAST = OP_DEC + REG_SPAN;
   localparam logic [7:0] OP_PUSH = 8'h50;
   localparam logic [7:0] OP_PUSH_LAST = OP_PUSH + REG_SPAN;
   localparam logic [7:0] OP_POP = 8'h58;
   localparam logic [7:0] OP_POP_LAST = OP_POP + REG_SPAN;
   localparam logic [7:0] OP_PUSHAD = 8'h60;
   localparam logic [7:0] OP_PUSH_IMM = 8'h68;
   localparam logic [7:0] OP_MOV = 8'hB8;
   localparam logic [7:0] OP_MOV_LAST = 8'hBF;
   localparam logic [7:0] OP_RETN = 8'hC3;
   localparam logic [7:0] OP_CALL = 8'hE8;
   localparam logic [7:0] OP_JMP = 8'hEB;

   localparam logic CSR_IMAGE_BASE = 1'b0;
   localparam logic CSR_FILE_SIZE = 1'b1;

   localparam logic [WORD_W-1:0] IMAGE_BASE_RESET = 32'h0040_0000;
   localparam logic [WORD_W-1:0] FILE_SIZE_RESET = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      STAT_OK = 3'd0,
      STAT_INVALID = 3'd1,
      STAT_EMPTY = 3'd2,
      STAT_OUTSIDE = 3'd3,
      STAT_FULL = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      CL_INC,
      CL_DEC,
      CL_PUSH,
      CL_POP,
      CL_PUSHAD,
      CL_PUSH_IMM,
      CL_MOV,
      CL_RETN,
      CL_CALL,
      CL_JMP,
      CL_BAD
   } op_class_type;

   typedef struct packed {
      logic en;
      logic [REG_AW-1:0] addr;
      logic [WORD_W-1:0] data;
   } reg_wr_type;

   function automatic op_class_type decode_op(input logic [7:0] op);
      op_class_type cls;
      unique case (op) inside
         [OP_INC : OP_INC_LAST]: cls = CL_INC;
         [OP_DEC : OP_DEC_LAST]: cls = CL_DEC;
         [OP_PUSH : OP_PUSH_LAST]: cls = CL_PUSH;
         [OP_POP : OP_POP_LAST]: cls = CL_POP;
         OP_PUSHAD: cls = CL_PUSHAD;
         OP_PUSH_IMM: cls = CL_PUSH_IMM;
         [OP_MOV : OP_MOV_LAST]: cls = CL_MOV;
         OP_RETN: cls = CL_RETN;
         OP_CALL: cls = CL_CALL;
         OP_JMP: cls = CL_JMP;
         default: cls = CL_BAD;
      endcase
      return cls;
   endfunction

endpackage

>>> sv/xpt_regs.sv
module xpt_regs (
   input  logic clock,
   input  logic reset,
   input  logic clear,
   input  xpt_pkg::reg_wr_type wr,
   input  logic [xpt_pkg::REG_AW-1:0] rd_addr,
   output logic [xpt_pkg::WORD_W-1:0] rd_data
);

   // Entries whose valid bit is clear read as zero, so a clear only resets the valid bits.
   logic [xpt_pkg::WORD_W-1:0] regs_mem [xpt_pkg::REG_COUNT];
   logic [xpt_pkg::REG_COUNT-1:0] valid_ff;
   logic [xpt_pkg::WORD_W-1:0] rd_word_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_mem[wr.addr] <= wr.data;
      end
      rd_word_ff <= regs_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

>>> sv/x86_subset_position_tracer_unit.sv
// Channel  Dir  Word contents (lowest bits first)
// req_*    in   tdata start_position, opcode, immediate; tuser start_run,
//               load_position; tlast last_instruction
// rsp_*    out  tdata new_position, status; tuser position_is_rva; tlast run_done
// csr_*    in   csr_index selects image_base (0) or file_size (1)
//
// An instruction runs from acceptance to its result word through S_READ (read register
// file and stack memory), S_EXEC (execute and write back) and S_DONE (load the output
// register); no new word is taken meanwhile. PUSHAD adds S_PUSHA, pushing the eight
// registers through the single stack write port one per cycle. Reset clears position,
// stack count and register valid bits and presets the configuration. A stalled result
// holds the output register while the next instruction is accepted and executed.
module x86_subset_position_tracer_unit #(
   parameter int unsigned STACK_DEPTH = xpt_pkg::STACK_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [xpt_pkg::REQ_TDATA_W-1:0] req_tdata, // start_position, opcode, immediate
   input  logic [xpt_pkg::REQ_TUSER_W-1:0] req_tuser, // start_run, load_position
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [xpt_pkg::RSP_TDATA_W-1:0] rsp_tdata, // new_position, status, zero pad
   output logic [0:0] rsp_tuser,                      // position_is_rva
   output logic rsp_tlast,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [xpt_pkg::WORD_W-1:0] csr_data
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned W = xpt_pkg::WORD_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] PUSHAD_ROOM = CW'(STACK_DEPTH - xpt_pkg::PUSHAD_COUNT);
   localparam logic [3:0] PUSHA_END = 4'(xpt_pkg::PUSHAD_COUNT);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_PUSHA, S_DONE} state_type;

   state_type state_ff, state_in;
   logic [7:0] op_ff, op_in;
   xpt_pkg::op_class_type class_ff, class_in;
   logic [W-1:0] imm_ff, imm_in;
   logic last_ff, last_in;
   logic [W-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0] next_ff, next_in;
   xpt_pkg::status_type pre_ff, pre_in;
   logic [3:0] k_ff, k_in;
   logic [W-1:0] res_pos_ff, res_pos_in;
   logic res_rva_ff, res_rva_in;
   xpt_pkg::status_type res_status_ff, res_status_in;
   logic res_last_ff, res_last_in;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [xpt_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic rsp_rva_ff, rsp_rva_in;
   logic rsp_last_ff, rsp_last_in;
   logic [W-1:0] image_base_ff, file_size_ff;

   logic accept;
   logic clear_regs;
   xpt_pkg::reg_wr_type reg_wr;
   logic [xpt_pkg::REG_AW-1:0] reg_raddr;
   logic [W-1:0] reg_rdata;

   logic [W-1:0] stack_mem [STACK_DEPTH];
   logic [W-1:0] stk_rdata_ff;
   logic stk_we;
   logic [W-1:0] stk_wdata;
   logic [CW-1:0] cnt_dec;
   logic [AW-1:0] stk_raddr;
   logic [AW-1:0] stk_waddr;

   logic [W-1:0] step;
   logic [W-1:0] rva;
   logic outside;
   xpt_pkg::status_type fin_status;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign clear_regs = accept && req_tuser[0];

   assign cnt_dec = cnt_ff - CW'(1);
   assign stk_raddr = cnt_dec[AW-1:0];
   assign stk_waddr = cnt_ff[AW-1:0];
   assign rva = stk_rdata_ff - image_base_ff;
   assign outside = (pre_ff == xpt_pkg::STAT_OK) && (class_ff != xpt_pkg::CL_RETN)
                    && (next_ff >= file_size_ff);
   assign fin_status = outside ? xpt_pkg::STAT_OUTSIDE : pre_ff;

   always_comb begin
      unique case (class_ff)
         xpt_pkg::CL_PUSH_IMM, xpt_pkg::CL_MOV: step = W'(5);
         xpt_pkg::CL_CALL: step = imm_ff + W'(5);
         xpt_pkg::CL_JMP: step = {{(W-8){imm_ff[7]}}, imm_ff[7:0]} + W'(2);
         default: step = W'(1);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      class_in = class_ff;
      imm_in = imm_ff;
      last_in = last_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      next_in = next_ff;
      pre_in = pre_ff;
      k_in = k_ff;
      res_pos_in = res_pos_ff;
      res_rva_in = res_rva_ff;
      res_status_in = res_status_ff;
      res_last_in = res_last_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_pos_in = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rva_in = rsp_rva_ff;
      rsp_last_in = rsp_last_ff;
      reg_wr = '0;
      reg_raddr = op_ff[xpt_pkg::REG_AW-1:0];
      stk_we = 1'b0;
      stk_wdata = reg_rdata;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_tdata[39:32];
               class_in = xpt_pkg::decode_op(req_tdata[39:32]);
               imm_in = req_tdata[71:40];
               last_in = req_tlast;
               if (req_tuser[0]) begin
                  cnt_in = '0;
               end
               if (req_tuser[0] || req_tuser[1]) begin
                  pos_in = req_tdata[31:0];
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            next_in = pos_ff + step;
            unique case (class_ff)
               xpt_pkg::CL_PUSH, xpt_pkg::CL_PUSH_IMM:
                  pre_in = (cnt_ff >= DEPTH_C) ? xpt_pkg::STAT_FULL : xpt_pkg::STAT_OK;
               xpt_pkg::CL_POP, xpt_pkg::CL_RETN:
                  pre_in = (cnt_ff == '0) ? xpt_pkg::STAT_EMPTY : xpt_pkg::STAT_OK;
               xpt_pkg::CL_PUSHAD:
                  pre_in = (cnt_ff > PUSHAD_ROOM) ? xpt_pkg::STAT_FULL : xpt_pkg::STAT_OK;
               xpt_pkg::CL_BAD: pre_in = xpt_pkg::STAT_INVALID;
               default: pre_in = xpt_pkg::STAT_OK;
            endcase
            state_in = S_EXEC;
         end
         S_EXEC: begin
            reg_wr.addr = op_ff[xpt_pkg::REG_AW-1:0];
            unique case (class_ff)
               xpt_pkg::CL_INC: begin
                  reg_wr.en = (fin_status == xpt_pkg::STAT_OK);
                  reg_wr.data = reg_rdata + W'(1);
               end
               xpt_pkg::CL_DEC: begin
                  reg_wr.en = (fin_status == xpt_pkg::STAT_OK);
                  reg_wr.data = reg_rdata - W'(1);
               end
               xpt_pkg::CL_POP: begin
                  reg_wr.en = (fin_status == xpt_pkg::STAT_OK)
                              || (fin_status == xpt_pkg::STAT_OUTSIDE);
                  reg_wr.data = (fin_status == xpt_pkg::STAT_OK) ? stk_rdata_ff : '0;
                  if (fin_status == xpt_pkg::STAT_OK) begin
                     cnt_in = cnt_dec;
                  end
               end
               xpt_pkg::CL_MOV: begin
                  reg_wr.en = 1'b1;
                  reg_wr.data = imm_ff;
               end
               xpt_pkg::CL_PUSH, xpt_pkg::CL_PUSH_IMM: begin
                  stk_we = (fin_status == xpt_pkg::STAT_OK);
                  stk_wdata = (class_ff == xpt_pkg::CL_PUSH) ? reg_rdata : imm_ff;
                  if (fin_status == xpt_pkg::STAT_OK) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
               xpt_pkg::CL_RETN: begin
                  if (fin_status == xpt_pkg::STAT_OK) begin
                     cnt_in = cnt_dec;
                  end
               end
               default: begin
               end
            endcase

            res_status_in = fin_status;
            res_last_in = last_ff;
            res_rva_in = (class_ff == xpt_pkg::CL_RETN) && (fin_status == xpt_pkg::STAT_OK);
            if (fin_status == xpt_pkg::STAT_OK || fin_status == xpt_pkg::STAT_OUTSIDE) begin
               res_pos_in = (class_ff == xpt_pkg::CL_RETN) ? rva : next_ff;
            end else begin
               res_pos_in = pos_ff;
            end
            if (fin_status == xpt_pkg::STAT_OK) begin
               pos_in = (class_ff == xpt_pkg::CL_RETN) ? rva : next_ff;
            end

            k_in = '0;
            if (class_ff == xpt_pkg::CL_PUSHAD && fin_status == xpt_pkg::STAT_OK) begin
               state_in = S_PUSHA;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PUSHA: begin
            // Register k is read while register k-1 goes onto the stack.
            reg_raddr = k_ff[xpt_pkg::REG_AW-1:0];
            if (k_ff != '0) begin
               stk_we = 1'b1;
               stk_wdata = reg_rdata;
               cnt_in = cnt_ff + CW'(1);
            end
            k_in = k_ff + 4'd1;
            if (k_ff == PUSHA_END) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_pos_in = res_pos_ff;
               rsp_status_in = res_status_ff;
               rsp_rva_in = res_rva_ff;
               rsp_last_in = res_last_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= '0;
         cnt_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         image_base_ff <= xpt_pkg::IMAGE_BASE_RESET;
         file_size_ff <= xpt_pkg::FILE_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               xpt_pkg::CSR_IMAGE_BASE: image_base_ff <= csr_data;
               xpt_pkg::CSR_FILE_SIZE: file_size_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      op_ff <= op_in;
      class_ff <= class_in;
      imm_ff <= imm_in;
      last_ff <= last_in;
      next_ff <= next_in;
      pre_ff <= pre_in;
      k_ff <= k_in;
      res_pos_ff <= res_pos_in;
      res_rva_ff <= res_rva_in;
      res_status_ff <= res_status_in;
      res_last_ff <= res_last_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rva_ff <= rsp_rva_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stack_mem[stk_raddr];
   end

   xpt_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_regs),
      .wr      (reg_wr),
      .rd_addr (reg_raddr),
      .rd_data (reg_rdata)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = {5'b0, rsp_status_ff, rsp_pos_ff};
   assign rsp_tuser = rsp_rva_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

>>> sv/xpt_checker.sv
`include "x86_subset_position_tracer_unit_assert.svh"

module xpt_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [xpt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0] rsp_tuser
);

   `XPT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "instruction accepted while another is executing")

   `XPT_ASSERT_NOW(a_rva_only_ok, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[34:32] == xpt_pkg::STAT_OK, "RVA flagged on a failed instruction")

   `XPT_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, (rsp_tdata[34:32] == xpt_pkg::STAT_OK) || (rsp_tdata[34:32] == xpt_pkg::STAT_INVALID) || (rsp_tdata[34:32] == xpt_pkg::STAT_EMPTY) || (rsp_tdata[34:32] == xpt_pkg::STAT_OUTSIDE) || (rsp_tdata[34:32] == xpt_pkg::STAT_FULL), "status code out of range")

   `XPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result word changed")

endmodule

bind x86_subset_position_tracer_unit xpt_checker u_checker (.*);
